@@ sv/ffd_pkg.sv @@
`default_nettype none

package ffd_pkg;

  localparam logic [7:0] HDR0  = 8'hFF;
  localparam logic [7:0] HDR1  = 8'hFE;
  localparam logic [7:0] TAIL0 = 8'h00;
  localparam logic [7:0] TAIL1 = 8'h01;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Wide enough for the frame index at payload lengths up to 124 bytes.
  localparam int unsigned STS_IDX_W = 7;

  typedef struct packed {
    logic [7:0] data;
    logic       is_hdr0;
    logic       is_hdr1;
    logic       is_tail0;
    logic       is_tail1;
  } rx_entry_t;

  typedef enum logic [1:0] {
    SYNC_HUNT,
    SYNC_FF,
    SYNC_LOCK
  } sync_e;

  typedef enum logic [2:0] {
    ENG_RUN,
    ENG_SCAN_RD,
    ENG_SCAN_PROC,
    ENG_EMIT_RD,
    ENG_EMIT_WR
  } eng_e;

  typedef struct packed {
    eng_e                 eng;
    sync_e                sync;
    logic [STS_IDX_W-1:0] fill;
    logic [STS_IDX_W-1:0] ptr;
  } eng_sts_t;

  function automatic rx_entry_t classify(input logic [7:0] b);
    rx_entry_t e;
    e.data     = b;
    e.is_hdr0  = (b == HDR0);
    e.is_hdr1  = (b == HDR1);
    e.is_tail0 = (b == TAIL0);
    e.is_tail1 = (b == TAIL1);
    return e;
  endfunction

endpackage

`default_nettype wire

@@ sv/ffd_ifs.sv @@
`default_nettype none

interface ffd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/fixed_frame_deframer.sv @@
// A good frame's first payload item passes the store read register and the output register.
// Throughput: one received byte per cycle while no frame is being emitted or rescanned.
// A good frame is emitted item by item: a store read, then a load once the output is free.
// A bad tail rescans buffered bytes, a read then a process state each; only the queue fills.
// Reset clears the queue, the sync state and the output valid flag; the store is not cleared.
`default_nettype none

module fixed_frame_deframer
  import ffd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffd_rx_if.sink    rx_i,
  ffd_tx_if.source  tx_o
);

  rx_entry_t qh_entry;
  logic      qh_valid;
  logic      qh_pop;
  eng_sts_t  sts;

  ffd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .qh_entry_o (qh_entry),
    .qh_valid_o (qh_valid),
    .qh_pop_i   (qh_pop)
  );

  ffd_engine #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_entry_i (qh_entry),
    .in_valid_i (qh_valid),
    .in_pop_o   (qh_pop),
    .tx_o       (tx_o),
    .sts_o      (sts)
  );

  // An item is only offered after the engine has loaded it from the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tx_o.valid) |-> $past(sts.eng) == ENG_EMIT_WR)
    else $error("payload item offered outside emission");

  // While locked the fill index stays within the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.sync == SYNC_LOCK |->
      (int'(sts.fill) >= 2) && (int'(sts.fill) <= int'(PAYLOAD_BYTES) + 3))
    else $error("fill index out of frame while locked");

  // During a rescan the compacting write stays behind the read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.eng == ENG_SCAN_PROC) && (sts.sync == SYNC_LOCK) |->
      (int'(sts.fill) + 2) <= int'(sts.ptr))
    else $error("rescan write overtook read");

  // No received byte is taken from the queue while the store is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qh_pop |-> (sts.eng == ENG_RUN) && qh_valid)
    else $error("queue popped while engine busy");

endmodule

`default_nettype wire

@@ sv/ffd_front.sv @@
`default_nettype none

module ffd_front
  import ffd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ffd_rx_if.sink     rx_i,
  output rx_entry_t  qh_entry_o,
  output logic       qh_valid_o,
  input  wire logic  qh_pop_i
);

  rx_entry_t          queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push;
  logic               pop;

  assign rx_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign qh_valid_o = (cnt_q != '0);
  assign qh_entry_o = queue_q[rd_ptr_q];

  assign push = rx_i.valid && rx_i.ready;
  assign pop  = qh_pop_i && qh_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= classify(rx_i.rx_byte);
    end
  end

endmodule

`default_nettype wire

@@ sv/ffd_engine.sv @@
`default_nettype none

module ffd_engine
  import ffd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rx_entry_t  in_entry_i,
  input  wire logic       in_valid_i,
  output logic            in_pop_o,
  ffd_tx_if.source        tx_o,
  output eng_sts_t        sts_o
);

  localparam int unsigned FRAME_BYTES = PAYLOAD_BYTES + 4;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] FIRST_PL = IDX_W'(2);
  localparam logic [IDX_W-1:0] LAST_PL  = IDX_W'(PAYLOAD_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic [7:0]       store_q [FRAME_BYTES];
  logic [7:0]       rd_data_q;

  eng_e             eng_q, eng_d;
  sync_e            sync_q, sync_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic             tail0_q, tail0_d;
  logic             out_valid_q;
  logic [7:0]       out_data_q;
  logic             out_last_q;

  rx_entry_t        cur;
  logic             proc_en;
  logic             rd_en;
  logic             wr_en;
  logic             frame_done;
  logic             tail_ok;
  logic             out_free;
  logic             out_load;

  assign out_free = !out_valid_q || tx_o.ready;

  // Control outputs of the sequencer.
  always_comb begin
    in_pop_o = 1'b0;
    rd_en    = 1'b0;
    proc_en  = 1'b0;
    out_load = 1'b0;
    cur      = in_entry_i;
    case (eng_q)
      ENG_RUN: begin
        in_pop_o = in_valid_i;
        proc_en  = in_valid_i;
      end
      ENG_SCAN_RD: begin
        rd_en = 1'b1;
      end
      ENG_SCAN_PROC: begin
        proc_en = 1'b1;
        cur     = classify(rd_data_q);
      end
      ENG_EMIT_RD: begin
        rd_en = 1'b1;
      end
      ENG_EMIT_WR: begin
        out_load = out_free;
      end
      default: begin
        in_pop_o = 1'b0;
      end
    endcase
  end

  // Byte-wise header search and frame fill.
  always_comb begin
    sync_d     = sync_q;
    fill_d     = fill_q;
    tail0_d    = tail0_q;
    wr_en      = 1'b0;
    frame_done = 1'b0;
    if (proc_en) begin
      tail0_d = cur.is_tail0;
      case (sync_q)
        SYNC_HUNT: begin
          if (cur.is_hdr0) begin
            sync_d = SYNC_FF;
          end
        end
        SYNC_FF: begin
          if (cur.is_hdr1) begin
            sync_d = SYNC_LOCK;
            fill_d = FIRST_PL;
          end else if (cur.is_hdr0) begin
            sync_d = SYNC_FF;
          end else begin
            sync_d = SYNC_HUNT;
          end
        end
        SYNC_LOCK: begin
          wr_en = 1'b1;
          if (fill_q == LAST_IDX) begin
            frame_done = 1'b1;
            sync_d     = SYNC_HUNT;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
        default: begin
          sync_d = SYNC_HUNT;
        end
      endcase
    end
  end

  assign tail_ok = tail0_q && cur.is_tail1;

  // Next state of the sequencer.
  always_comb begin
    eng_d = eng_q;
    ptr_d = ptr_q;
    case (eng_q)
      ENG_RUN: begin
        if (frame_done) begin
          ptr_d = FIRST_PL;
          eng_d = tail_ok ? ENG_EMIT_RD : ENG_SCAN_RD;
        end
      end
      ENG_SCAN_RD: begin
        eng_d = ENG_SCAN_PROC;
      end
      ENG_SCAN_PROC: begin
        if (ptr_q == LAST_IDX) begin
          eng_d = ENG_RUN;
        end else begin
          ptr_d = ptr_q + 1'b1;
          eng_d = ENG_SCAN_RD;
        end
      end
      ENG_EMIT_RD: begin
        eng_d = ENG_EMIT_WR;
      end
      ENG_EMIT_WR: begin
        if (out_free) begin
          if (ptr_q == LAST_PL) begin
            eng_d = ENG_RUN;
          end else begin
            ptr_d = ptr_q + 1'b1;
            eng_d = ENG_EMIT_RD;
          end
        end
      end
      default: begin
        eng_d = ENG_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q       <= ENG_RUN;
      sync_q      <= SYNC_HUNT;
      fill_q      <= '0;
      ptr_q       <= '0;
      tail0_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      eng_q   <= eng_d;
      sync_q  <= sync_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      tail0_q <= tail0_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[fill_q] <= cur.data;
    end
    if (rd_en) begin
      rd_data_q <= store_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= rd_data_q;
      out_last_q <= (ptr_q == LAST_PL);
    end
  end

  assign tx_o.valid        = out_valid_q;
  assign tx_o.payload_byte = out_data_q;
  assign tx_o.last_byte    = out_last_q;

  assign sts_o.eng  = eng_q;
  assign sts_o.sync = sync_q;
  assign sts_o.fill = STS_IDX_W'(fill_q);
  assign sts_o.ptr  = STS_IDX_W'(ptr_q);

endmodule

`default_nettype wire
